// File: rtl/sqg_pkg.sv
// ----------------------------------------------------------------------------
// sqg_pkg
// Shared types and constants for the single-qubit gate datapath.
// ----------------------------------------------------------------------------
package sqg_pkg;

  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 30;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic signed [COEF_W-1:0] Q_ONE    = 32'sh4000_0000;
  localparam logic signed [COEF_W-1:0] Q_HALF   = 32'sh2000_0000;
  localparam logic signed [COEF_W-1:0] Q_RSQRT2 = 32'sd759250125;

  // gate codes
  localparam logic [3:0] OP_H  = 4'd0;
  localparam logic [3:0] OP_X  = 4'd1;
  localparam logic [3:0] OP_Y  = 4'd2;
  localparam logic [3:0] OP_Z  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_RX = 4'd5;
  localparam logic [3:0] OP_SX = 4'd6;
  localparam logic [3:0] OP_RY = 4'd7;
  localparam logic [3:0] OP_RZ = 4'd8;
  localparam logic [3:0] OP_P  = 4'd9;
  localparam logic [3:0] OP_U  = 4'd10;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_ROT_COS = 3'd0;
  localparam logic [2:0] REG_ROT_SIN = 3'd1;
  localparam logic [2:0] REG_MAT00   = 3'd2;
  localparam logic [2:0] REG_MAT01   = 3'd3;
  localparam logic [2:0] REG_MAT10   = 3'd4;
  localparam logic [2:0] REG_MAT11   = 3'd5;

  // coefficient with a separate negate flag, so -(-2^31) needs no 33rd bit
  typedef struct packed {
    logic signed [COEF_W-1:0] val;
    logic                     neg;
  } coef_t;

  typedef coef_t [3:0] coef_row_t;
  typedef coef_row_t [3:0] coef_mat_t;

  typedef struct packed {
    logic [COEF_W-1:0]          rot_cos;
    logic [COEF_W-1:0]          rot_sin;
    logic [3:0][2*COEF_W-1:0]   mat;
  } cfg_t;

  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_d;
  } pipe_en_t;

  localparam coef_t C_ZERO = '{val: '0, neg: 1'b0};

  function automatic coef_t mk(input logic [COEF_W-1:0] v, input logic n);
    coef_t r;
    r.val = $signed(v);
    r.neg = n;
    return r;
  endfunction

  function automatic coef_row_t row(input coef_t c0, input coef_t c1,
                                    input coef_t c2, input coef_t c3);
    coef_row_t r;
    r[0] = c0;
    r[1] = c1;
    r[2] = c2;
    r[3] = c3;
    return r;
  endfunction

endpackage

// File: rtl/sqg_cfg.sv
// ----------------------------------------------------------------------------
// sqg_cfg
// APB register file: rotation cosine/sine and the four U matrix elements.
// ----------------------------------------------------------------------------
module sqg_cfg
  import sqg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ROT_COS: cfg_d.rot_cos = pwdata[COEF_W-1:0];
        REG_ROT_SIN: cfg_d.rot_sin = pwdata[COEF_W-1:0];
        REG_MAT00:   cfg_d.mat[0]  = pwdata;
        REG_MAT01:   cfg_d.mat[1]  = pwdata;
        REG_MAT10:   cfg_d.mat[2]  = pwdata;
        REG_MAT11:   cfg_d.mat[3]  = pwdata;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROT_COS: prdata = {{COEF_W{1'b0}}, cfg_q.rot_cos};
      REG_ROT_SIN: prdata = {{COEF_W{1'b0}}, cfg_q.rot_sin};
      REG_MAT00:   prdata = cfg_q.mat[0];
      REG_MAT01:   prdata = cfg_q.mat[1];
      REG_MAT10:   prdata = cfg_q.mat[2];
      REG_MAT11:   prdata = cfg_q.mat[3];
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_cos <= Q_ONE;
      cfg_q.rot_sin <= '0;
      cfg_q.mat[0]  <= {Q_ONE, {COEF_W{1'b0}}};
      cfg_q.mat[1]  <= '0;
      cfg_q.mat[2]  <= '0;
      cfg_q.mat[3]  <= {Q_ONE, {COEF_W{1'b0}}};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/sqg_coef_sel.sv
// ----------------------------------------------------------------------------
// sqg_coef_sel
// Builds the real 4x4 coefficient matrix of the chosen gate.
// ----------------------------------------------------------------------------
module sqg_coef_sel
  import sqg_pkg::*;
(
  input  logic [3:0] op_i,
  input  cfg_t       cfg_i,
  output coef_mat_t  mat_o
);

  coef_t one, neg1, k, nk, h, nh, c, s, ns;
  coef_t pr [4];
  coef_t pi [4];
  coef_t npi [4];

  always_comb begin
    one  = mk(Q_ONE, 1'b0);
    neg1 = mk(Q_ONE, 1'b1);
    k    = mk(Q_RSQRT2, 1'b0);
    nk   = mk(Q_RSQRT2, 1'b1);
    h    = mk(Q_HALF, 1'b0);
    nh   = mk(Q_HALF, 1'b1);
    c    = mk(cfg_i.rot_cos, 1'b0);
    s    = mk(cfg_i.rot_sin, 1'b0);
    ns   = mk(cfg_i.rot_sin, 1'b1);
    for (int i = 0; i < 4; i++) begin
      pr[i]  = mk(cfg_i.mat[i][2*COEF_W-1:COEF_W], 1'b0);
      pi[i]  = mk(cfg_i.mat[i][COEF_W-1:0], 1'b0);
      npi[i] = mk(cfg_i.mat[i][COEF_W-1:0], 1'b1);
    end

    // identity; Z, S and P only touch the second amplitude
    mat_o[0] = row(one, C_ZERO, C_ZERO, C_ZERO);
    mat_o[1] = row(C_ZERO, one, C_ZERO, C_ZERO);
    mat_o[2] = row(C_ZERO, C_ZERO, one, C_ZERO);
    mat_o[3] = row(C_ZERO, C_ZERO, C_ZERO, one);

    unique case (op_i)
      OP_H: begin
        mat_o[0] = row(k, C_ZERO, k, C_ZERO);
        mat_o[1] = row(C_ZERO, k, C_ZERO, k);
        mat_o[2] = row(k, C_ZERO, nk, C_ZERO);
        mat_o[3] = row(C_ZERO, k, C_ZERO, nk);
      end
      OP_X: begin
        mat_o[0] = row(C_ZERO, C_ZERO, one, C_ZERO);
        mat_o[1] = row(C_ZERO, C_ZERO, C_ZERO, one);
        mat_o[2] = row(one, C_ZERO, C_ZERO, C_ZERO);
        mat_o[3] = row(C_ZERO, one, C_ZERO, C_ZERO);
      end
      OP_Y: begin
        mat_o[0] = row(C_ZERO, C_ZERO, C_ZERO, one);
        mat_o[1] = row(C_ZERO, C_ZERO, neg1, C_ZERO);
        mat_o[2] = row(C_ZERO, neg1, C_ZERO, C_ZERO);
        mat_o[3] = row(one, C_ZERO, C_ZERO, C_ZERO);
      end
      OP_Z: begin
        mat_o[2] = row(C_ZERO, C_ZERO, neg1, C_ZERO);
        mat_o[3] = row(C_ZERO, C_ZERO, C_ZERO, neg1);
      end
      OP_S: begin
        mat_o[2] = row(C_ZERO, C_ZERO, C_ZERO, neg1);
        mat_o[3] = row(C_ZERO, C_ZERO, one, C_ZERO);
      end
      OP_RX: begin
        mat_o[0] = row(c, C_ZERO, C_ZERO, s);
        mat_o[1] = row(C_ZERO, c, ns, C_ZERO);
        mat_o[2] = row(C_ZERO, s, c, C_ZERO);
        mat_o[3] = row(ns, C_ZERO, C_ZERO, c);
      end
      OP_SX: begin
        mat_o[0] = row(h, nh, h, h);
        mat_o[1] = row(h, h, nh, h);
        mat_o[2] = row(h, h, h, nh);
        mat_o[3] = row(nh, h, h, h);
      end
      OP_RY: begin
        mat_o[0] = row(c, C_ZERO, ns, C_ZERO);
        mat_o[1] = row(C_ZERO, c, C_ZERO, ns);
        mat_o[2] = row(s, C_ZERO, c, C_ZERO);
        mat_o[3] = row(C_ZERO, s, C_ZERO, c);
      end
      OP_RZ: begin
        mat_o[0] = row(c, s, C_ZERO, C_ZERO);
        mat_o[1] = row(ns, c, C_ZERO, C_ZERO);
        mat_o[2] = row(C_ZERO, C_ZERO, c, ns);
        mat_o[3] = row(C_ZERO, C_ZERO, s, c);
      end
      OP_P: begin
        mat_o[2] = row(C_ZERO, C_ZERO, c, ns);
        mat_o[3] = row(C_ZERO, C_ZERO, s, c);
      end
      OP_U: begin
        mat_o[0] = row(pr[0], npi[0], pr[1], npi[1]);
        mat_o[1] = row(pi[0], pr[0], pi[1], pr[1]);
        mat_o[2] = row(pr[2], npi[2], pr[3], npi[3]);
        mat_o[3] = row(pi[2], pr[2], pi[3], pr[3]);
      end
      default: ;  // unused codes pass through
    endcase
  end

endmodule

// File: rtl/sqg_lane.sv
// ----------------------------------------------------------------------------
// sqg_lane
// One output part: four amplitude x coefficient products, summed, rounded
// half up by the coefficient fraction and saturated.
// ----------------------------------------------------------------------------
module sqg_lane
  import sqg_pkg::*;
#(
  parameter int AMP_WIDTH = 32
) (
  input  logic                      clk_i,
  input  pipe_en_t                  en_i,
  input  logic [3:0][AMP_WIDTH-1:0] amp_i,
  input  coef_row_t                 coef_i,
  output logic [AMP_WIDTH-1:0]      res_o
);

  localparam int LO_W   = AMP_WIDTH / 2;
  localparam int HI_W   = AMP_WIDTH - LO_W;
  localparam int PLO_W  = LO_W + COEF_W + 1;
  localparam int PHI_W  = HI_W + COEF_W;
  localparam int PROD_W = AMP_WIDTH + COEF_W + 1;
  localparam int SUM_W  = AMP_WIDTH + COEF_W + 3;
  localparam int SH_W   = SUM_W - COEF_FRAC;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (COEF_FRAC - 1);
  localparam logic [AMP_WIDTH-1:0] SAT_MAX = {1'b0, {(AMP_WIDTH-1){1'b1}}};
  localparam logic [AMP_WIDTH-1:0] SAT_MIN = {1'b1, {(AMP_WIDTH-1){1'b0}}};

  logic signed [PLO_W-1:0]  plo_q  [4];
  logic signed [PHI_W-1:0]  phi_q  [4];
  logic                     neg_q  [4];
  logic signed [PROD_W-1:0] prod_q [4];
  logic signed [PROD_W-1:0] prod_d [4];
  logic signed [SUM_W-1:0]  p01_q, p23_q;
  logic signed [SUM_W-1:0]  sum;
  logic [SH_W-1:0]          sh;
  logic                     fits;

  // product split in two halves of the amplitude to keep each multiplier small
  for (genvar g = 0; g < 4; g++) begin : g_prod
    logic signed [PLO_W-1:0] plo_d;
    logic signed [PHI_W-1:0] phi_d;

    assign plo_d = $signed({1'b0, amp_i[g][LO_W-1:0]}) * $signed(coef_i[g].val);
    assign phi_d = $signed(amp_i[g][AMP_WIDTH-1:LO_W]) * $signed(coef_i[g].val);

    always_ff @(posedge clk_i) begin
      if (en_i.en_b) begin
        plo_q[g] <= plo_d;
        phi_q[g] <= phi_d;
        neg_q[g] <= coef_i[g].neg;
      end
    end

    always_comb begin
      prod_d[g] = (PROD_W'(phi_q[g]) <<< LO_W) + PROD_W'(plo_q[g]);
      if (neg_q[g]) begin
        prod_d[g] = -prod_d[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i.en_c) begin
        prod_q[g] <= prod_d[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_d) begin
      p01_q <= SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]);
      p23_q <= SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]);
    end
  end

  assign sum  = p01_q + p23_q + RND;
  assign sh   = sum[SUM_W-1:COEF_FRAC];
  assign fits = (&sh[SH_W-1:AMP_WIDTH-1]) || !(|sh[SH_W-1:AMP_WIDTH-1]);

  always_comb begin
    if (fits) begin
      res_o = sh[AMP_WIDTH-1:0];
    end else if (sh[SH_W-1]) begin
      res_o = SAT_MIN;
    end else begin
      res_o = SAT_MAX;
    end
  end

endmodule

// File: rtl/single_qubit_gate_apply.sv
// ----------------------------------------------------------------------------
// single_qubit_gate_apply
// Applies a single-qubit gate to one pair of complex state-vector amplitudes.
// A beat passes through the input, product, signed-product, pair-sum and result registers.
// Throughput: one pair per cycle while the output is not stalled; four lanes, one per output part, each with
// its own multipliers, so nothing is shared between pairs.
// Each stage holds its beat only while the stage after it is full.
// Reset clears all stage valids and loads the config registers with their defaults.
// ----------------------------------------------------------------------------
module single_qubit_gate_apply
  import sqg_pkg::*;
#(
  parameter int AMP_WIDTH  = 32,
  parameter int INDEX_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready,
  // input beat
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [3:0]                   op_i,
  input  logic [INDEX_BITS-1:0]        index_lo_i,
  input  logic [INDEX_BITS-1:0]        index_hi_i,
  input  logic signed [AMP_WIDTH-1:0]  amp0_re_i,
  input  logic signed [AMP_WIDTH-1:0]  amp0_im_i,
  input  logic signed [AMP_WIDTH-1:0]  amp1_re_i,
  input  logic signed [AMP_WIDTH-1:0]  amp1_im_i,
  // result beat
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [INDEX_BITS-1:0]        out_index_lo_o,
  output logic [INDEX_BITS-1:0]        out_index_hi_o,
  output logic signed [AMP_WIDTH-1:0]  new0_re_o,
  output logic signed [AMP_WIDTH-1:0]  new0_im_o,
  output logic signed [AMP_WIDTH-1:0]  new1_re_o,
  output logic signed [AMP_WIDTH-1:0]  new1_im_o
);

  cfg_t                      cfg;
  coef_mat_t                 mat_d, mat_q;
  logic [3:0][AMP_WIDTH-1:0] amp_q;
  logic [3:0][AMP_WIDTH-1:0] lane_res;
  pipe_en_t                  pipe_en;

  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [INDEX_BITS-1:0] idx_lo_q [4];
  logic [INDEX_BITS-1:0] idx_hi_q [4];
  logic [INDEX_BITS-1:0] out_idx_lo_q, out_idx_hi_q;
  logic [3:0][AMP_WIDTH-1:0] out_res_q;

  sqg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sqg_coef_sel u_coef_sel (
    .op_i  (op_i),
    .cfg_i (cfg),
    .mat_o (mat_d)
  );

  // a stage may take a beat when empty or when its own beat moves on
  assign rdy5 = !out_valid_q || !out_stall_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  assign pipe_en.en_b = rdy2;
  assign pipe_en.en_c = rdy3;
  assign pipe_en.en_d = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy5) begin
        out_valid_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      mat_q       <= mat_d;
      amp_q[0]    <= amp0_re_i;
      amp_q[1]    <= amp0_im_i;
      amp_q[2]    <= amp1_re_i;
      amp_q[3]    <= amp1_im_i;
      idx_lo_q[0] <= index_lo_i;
      idx_hi_q[0] <= index_hi_i;
    end
    if (rdy2) begin
      idx_lo_q[1] <= idx_lo_q[0];
      idx_hi_q[1] <= idx_hi_q[0];
    end
    if (rdy3) begin
      idx_lo_q[2] <= idx_lo_q[1];
      idx_hi_q[2] <= idx_hi_q[1];
    end
    if (rdy4) begin
      idx_lo_q[3] <= idx_lo_q[2];
      idx_hi_q[3] <= idx_hi_q[2];
    end
    if (rdy5) begin
      out_idx_lo_q <= idx_lo_q[3];
      out_idx_hi_q <= idx_hi_q[3];
      out_res_q    <= lane_res;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    sqg_lane #(
      .AMP_WIDTH (AMP_WIDTH)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (pipe_en),
      .amp_i  (amp_q),
      .coef_i (mat_q[l]),
      .res_o  (lane_res[l])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign out_index_lo_o = out_idx_lo_q;
  assign out_index_hi_o = out_idx_hi_q;
  assign new0_re_o      = out_res_q[0];
  assign new0_im_o      = out_res_q[1];
  assign new1_re_o      = out_res_q[2];
  assign new1_im_o      = out_res_q[3];

  // input only backs up when every stage holds a beat
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_valid_q))
    else $error("input stalled with an empty stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v1_q)
    else $error("accepted beat lost at stage 1");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !out_stall_i |=> out_valid_q)
    else $error("beat lost between last stage and output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy4 |=> v3_q)
    else $error("stalled beat dropped in stage 3");

endmodule
